// File: src/fpdc_pkg.sv
// Shared types and constants for the six-axis force PD compensator.
// Holds the queue item, the gain bundle, the gain register map, deadbands,
// clamp limits and the reciprocal constants used by the rounding divider. No dependencies.
package fpdc_pkg;

  localparam int AXES    = 6;
  localparam int AXIS_W  = 3;
  localparam int IN_W    = 22;
  localparam int GAIN_W  = 16;
  localparam int DB_W    = 12;
  localparam int LIM_W   = 17;
  localparam int RES_W   = 18;
  localparam int N_W     = 27;
  localparam int Q_W     = 17;
  localparam int ACC_W   = 40;

  // Axis codes, in field order
  localparam logic [AXIS_W-1:0] AX_FX = 3'd0;
  localparam logic [AXIS_W-1:0] AX_FY = 3'd1;
  localparam logic [AXIS_W-1:0] AX_FZ = 3'd2;
  localparam logic [AXIS_W-1:0] AX_TX = 3'd3;
  localparam logic [AXIS_W-1:0] AX_TY = 3'd4;
  localparam logic [AXIS_W-1:0] AX_TZ = 3'd5;
  localparam logic [AXIS_W-1:0] LAST_AXIS = AX_TZ;

  // Gain register map of the config port
  typedef enum logic [2:0] {
    REG_KP_FORCE_XY,
    REG_KD_FORCE_XY,
    REG_KP_FORCE_Z,
    REG_KD_FORCE_Z,
    REG_KP_TORQUE,
    REG_KD_TORQUE
  } cfg_reg_t;

  // Force path: round(mag/250) = floor(floor((mag+125)/2) / 125)
  localparam int FORCE_HALF = 125;
  localparam int FORCE_K    = 29;
  localparam logic [22:0] FORCE_MUL = 23'(((64'd1 << FORCE_K) + 64'd124) / 64'd125);
  localparam logic [ACC_W-1:0] FORCE_SAT = 40'd9175250;     // 250 * 36701, over every force clamp

  // Torque path: round(mag*157/2250) = floor(floor((mag*157+1125)/2) / 1125)
  localparam int TORQUE_NUM  = 157;
  localparam int TORQUE_HALF = 1125;
  localparam int TORQUE_K    = 38;
  localparam logic [27:0] TORQUE_MUL = 28'(((64'd1 << TORQUE_K) + 64'd1124) / 64'd1125);
  localparam logic [ACC_W-1:0] TORQUE_SAT = 40'd1310396;    // first mag giving 91437+

  typedef struct packed {
    logic [AXES-1:0]           act;   // axis outside its deadband
    logic [AXES-1:0][IN_W-1:0] err;   // error shrunk by the deadband
  } item_t;

  typedef struct packed {
    logic        [GAIN_W-1:0] kp_xy;
    logic signed [GAIN_W-1:0] kd_xy;
    logic        [GAIN_W-1:0] kp_z;
    logic signed [GAIN_W-1:0] kd_z;
    logic        [GAIN_W-1:0] kp_t;
    logic signed [GAIN_W-1:0] kd_t;
  } gains_t;

  function automatic logic [DB_W-1:0] dead_band(input logic [AXIS_W-1:0] axis);
    logic [DB_W-1:0] db;
    case (axis)
      AX_FX, AX_FY: db = 12'd1536;
      AX_FZ:        db = 12'd3072;
      default:      db = 12'd154;
    endcase
    return db;
  endfunction

  function automatic logic [LIM_W-1:0] out_limit(input logic [AXIS_W-1:0] axis);
    logic [LIM_W-1:0] lim;
    case (axis)
      AX_FX, AX_FY: lim = 17'd31457;
      AX_FZ:        lim = 17'd36700;
      default:      lim = 17'd91436;
    endcase
    return lim;
  endfunction

endpackage

// File: src/fpdc_front.sv
// Front end: takes a sample beat and classifies each axis against its
// deadband, producing the shrunk errors for the queue. Uses fpdc_pkg.
module fpdc_front (
  input  logic                    sample_valid,
  output logic                    sample_ready,
  input  logic signed [21:0]      force_x,
  input  logic signed [21:0]      force_y,
  input  logic signed [21:0]      force_z,
  input  logic signed [21:0]      torque_x,
  input  logic signed [21:0]      torque_y,
  input  logic signed [21:0]      torque_z,
  input  logic                    q_full,
  output logic                    q_push,
  output fpdc_pkg::item_t         q_item
);
  import fpdc_pkg::*;

  logic signed [IN_W-1:0] x [AXES];

  assign x[0] = force_x;
  assign x[1] = force_y;
  assign x[2] = force_z;
  assign x[3] = torque_x;
  assign x[4] = torque_y;
  assign x[5] = torque_z;

  assign sample_ready = !q_full;
  assign q_push       = sample_valid && !q_full;

  // Per-axis deadband test and shrink toward zero
  always_comb begin
    logic signed [IN_W:0] xs;
    logic signed [IN_W:0] dbs;
    logic signed [IN_W:0] e;
    q_item = '0;
    for (int i = 0; i < AXES; i++) begin
      xs  = $signed({x[i][IN_W-1], x[i]});
      dbs = $signed({{(IN_W+1-DB_W){1'b0}}, dead_band(AXIS_W'(i))});
      e   = (xs < 0) ? (xs + dbs) : (xs - dbs);
      q_item.act[i] = !((xs <= dbs) && (xs >= -dbs));
      q_item.err[i] = e[IN_W-1:0];
    end
  end

endmodule

// File: src/fpdc_queue.sv
// Small FIFO between the classifier and the PD datapath.
// Holds fpdc_pkg::item_t entries; depth of two or more.
module fpdc_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fpdc_pkg::item_t wr_item,
  input  logic            pop,
  output fpdc_pkg::item_t rd_item,
  output logic            not_empty,
  output logic            full
);
  import fpdc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            entries [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_item   = entries[rptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= wr_item;
    end
  end

endmodule

// File: src/fpdc_back.sv
// PD datapath: runs the six axes of one item through a shared five-stage
// multiply / round / clamp path, one axis per cycle unless a held result
// stalls it, and assembles the result. Uses fpdc_pkg.
module fpdc_back (
  input  logic                clk,
  input  logic                rst,
  input  fpdc_pkg::gains_t    gains,
  input  logic                q_valid,
  input  fpdc_pkg::item_t     q_item,
  output logic                q_pop,
  output logic                back_busy,
  output logic                result_valid,
  input  logic                result_ready,
  output logic signed [15:0]  move_x,
  output logic signed [15:0]  move_y,
  output logic signed [16:0]  move_z,
  output logic signed [17:0]  turn_x,
  output logic signed [17:0]  turn_y,
  output logic signed [17:0]  turn_z
);
  import fpdc_pkg::*;

  // Issue control
  logic              busy;
  logic [AXIS_W-1:0] cnt;
  item_t             cur;
  logic              stall;
  logic              issue;
  logic              last_issue;

  // Stored errors per axis
  logic signed [IN_W-1:0] prev [AXES];

  // Stage registers
  logic                     s1_valid, s2_valid, s3_valid, s4_valid;
  logic [AXIS_W-1:0]        s1_axis, s2_axis, s3_axis, s4_axis;
  logic                     s1_act, s2_act, s3_act, s4_act;
  logic signed [38:0]       s1_p1;
  logic signed [IN_W:0]     s1_d;
  logic signed [GAIN_W-1:0] s1_kd;
  logic signed [ACC_W-1:0]  s2_acc;
  logic                     s3_sat, s3_neg, s4_sat, s4_neg;
  logic [N_W-1:0]           s3_n;
  logic [Q_W-1:0]           s4_q;

  // Partial result assembly for the first five axes
  logic [RES_W-1:0] asm_res [LAST_AXIS];

  // Combinational per-stage values
  logic signed [IN_W-1:0]   e_sel;
  logic signed [IN_W-1:0]   prev_sel;
  logic                     act_sel;
  logic [GAIN_W-1:0]        kp_sel;
  logic signed [GAIN_W-1:0] kd_sel;
  logic signed [38:0]       p1_w;
  logic signed [IN_W:0]     d_w;
  logic signed [ACC_W-1:0]  acc_w;
  logic [ACC_W-1:0]         mag_w;
  logic                     torque_w;
  logic [23:0]              fsum_w;
  logic [28:0]              tmul_w;
  logic [28:0]              tsum_w;
  logic [N_W-1:0]           n_w;
  logic                     sat_w;
  logic [54:0]              prod_w;
  logic [Q_W-1:0]           q_w;
  logic [LIM_W-1:0]         lim_w;
  logic [LIM_W-1:0]         qc_w;
  logic [RES_W-1:0]         r_w;

  // Hold everything while the finished item cannot leave
  assign stall      = s4_valid && (s4_axis == LAST_AXIS) && result_valid && !result_ready;
  assign issue      = busy && !stall;
  assign last_issue = issue && (cnt == LAST_AXIS);
  assign q_pop      = q_valid && !stall && (!busy || last_issue);
  assign back_busy  = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (!stall) begin
      if (q_pop) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (last_issue) begin
        busy <= 1'b0;
      end else if (issue) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
  end

  // Stage 0: pick axis, gains, previous error; first product
  assign e_sel    = $signed(cur.err[cnt]);
  assign act_sel  = cur.act[cnt];
  assign prev_sel = prev[cnt];

  always_comb begin
    case (cnt)
      AX_FX, AX_FY: begin
        kp_sel = gains.kp_xy;
        kd_sel = gains.kd_xy;
      end
      AX_FZ: begin
        kp_sel = gains.kp_z;
        kd_sel = gains.kd_z;
      end
      default: begin
        kp_sel = gains.kp_t;
        kd_sel = gains.kd_t;
      end
    endcase
  end

  assign p1_w = $signed({1'b0, kp_sel}) * e_sel;
  assign d_w  = $signed({e_sel[IN_W-1], e_sel}) - $signed({prev_sel[IN_W-1], prev_sel});

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        prev[i] <= '0;
      end
    end else if (issue && act_sel) begin
      prev[cnt] <= e_sel;
    end
  end

  // Stage 1: derivative product and PD sum
  assign acc_w = s1_p1 + s1_kd * s1_d;

  // Stage 2: magnitude, saturation test, rounding numerator
  assign mag_w    = s2_acc[ACC_W-1] ? $unsigned(-s2_acc) : $unsigned(s2_acc);
  assign torque_w = (s2_axis >= AX_TX);
  assign fsum_w   = mag_w[23:0] + 24'(FORCE_HALF);
  assign tmul_w   = 29'(mag_w[20:0]) * 29'(TORQUE_NUM);
  assign tsum_w   = tmul_w + 29'(TORQUE_HALF);
  assign sat_w    = torque_w ? (mag_w >= TORQUE_SAT) : (mag_w >= FORCE_SAT);
  assign n_w      = torque_w ? tsum_w[N_W:1] : N_W'(fsum_w[23:1]);

  // Stage 3: divide by reciprocal multiply
  assign prod_w = 55'(s3_n) * ((s3_axis >= AX_TX) ? 55'(TORQUE_MUL) : 55'(FORCE_MUL));
  assign q_w    = (s3_axis >= AX_TX) ? prod_w[TORQUE_K +: Q_W] : prod_w[FORCE_K +: Q_W];

  // Stage 4: clamp and sign
  assign lim_w = out_limit(s4_axis);
  assign qc_w  = (s4_sat || (s4_q > lim_w)) ? lim_w : s4_q;
  assign r_w   = !s4_act ? '0 : (s4_neg ? (RES_W'(0) - {1'b0, qc_w}) : {1'b0, qc_w});

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (!stall) begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_axis <= cnt;
      s1_act  <= act_sel;
      s1_p1   <= p1_w;
      s1_d    <= d_w;
      s1_kd   <= kd_sel;
      s2_axis <= s1_axis;
      s2_act  <= s1_act;
      s2_acc  <= acc_w;
      s3_axis <= s2_axis;
      s3_act  <= s2_act;
      s3_sat  <= sat_w;
      s3_neg  <= s2_acc[ACC_W-1];
      s3_n    <= n_w;
      s4_axis <= s3_axis;
      s4_act  <= s3_act;
      s4_sat  <= s3_sat;
      s4_neg  <= s3_neg;
      s4_q    <= q_w;
    end
  end

  // Result assembly and output register
  always_ff @(posedge clk) begin
    if (s4_valid && !stall && (s4_axis != LAST_AXIS)) begin
      asm_res[s4_axis] <= r_w;
    end
    if (s4_valid && !stall && (s4_axis == LAST_AXIS)) begin
      move_x <= $signed(asm_res[AX_FX][15:0]);
      move_y <= $signed(asm_res[AX_FY][15:0]);
      move_z <= $signed(asm_res[AX_FZ][16:0]);
      turn_x <= $signed(asm_res[AX_TX]);
      turn_y <= $signed(asm_res[AX_TY]);
      turn_z <= $signed(r_w);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s4_valid && !stall && (s4_axis == LAST_AXIS)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

// File: src/six_axis_force_pd_compensator.sv
// Six-axis force/torque PD compensator with per-axis deadband and clamp.
// A sample beat is classified on entry and parked in a small queue
// (QUEUE_DEPTH entries); the PD datapath then handles its six axes one per
// cycle, unless a waiting result stalls it, through a single shared
// five-stage multiply, round and clamp path, which limits throughput; each
// next sample's axes follow right behind the last axis of the one before.
// The next samples are queued while a result waits to be taken.
// Gains are written through cfg_we/cfg_index/cfg_data while the block is
// idle, a rule for the user that the block does not enforce; unknown indexes
// are ignored. Depends on fpdc_pkg, fpdc_front, fpdc_queue and fpdc_back.
module six_axis_force_pd_compensator #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  logic signed [21:0]  force_x,
  input  logic signed [21:0]  force_y,
  input  logic signed [21:0]  force_z,
  input  logic signed [21:0]  torque_x,
  input  logic signed [21:0]  torque_y,
  input  logic signed [21:0]  torque_z,
  output logic                result_valid,
  input  logic                result_ready,
  output logic signed [15:0]  move_x,
  output logic signed [15:0]  move_y,
  output logic signed [16:0]  move_z,
  output logic signed [17:0]  turn_x,
  output logic signed [17:0]  turn_y,
  output logic signed [17:0]  turn_z
);
  import fpdc_pkg::*;

  gains_t gains;
  logic   q_full;
  logic   q_push;
  logic   q_pop;
  logic   q_valid;
  item_t  q_wr_item;
  item_t  q_rd_item;
  logic   back_busy;

  // Gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.kp_xy <= 16'd563;
      gains.kd_xy <= -16'sd102;
      gains.kp_z  <= 16'd384;
      gains.kd_z  <= -16'sd77;
      gains.kp_t  <= 16'd640;
      gains.kd_t  <= -16'sd128;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_KP_FORCE_XY: gains.kp_xy <= cfg_data;
        REG_KD_FORCE_XY: gains.kd_xy <= $signed(cfg_data);
        REG_KP_FORCE_Z:  gains.kp_z  <= cfg_data;
        REG_KD_FORCE_Z:  gains.kd_z  <= $signed(cfg_data);
        REG_KP_TORQUE:   gains.kp_t  <= cfg_data;
        REG_KD_TORQUE:   gains.kd_t  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  fpdc_front u_front (
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .force_x      (force_x),
    .force_y      (force_y),
    .force_z      (force_z),
    .torque_x     (torque_x),
    .torque_y     (torque_y),
    .torque_z     (torque_z),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_wr_item)
  );

  fpdc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_item   (q_wr_item),
    .pop       (q_pop),
    .rd_item   (q_rd_item),
    .not_empty (q_valid),
    .full      (q_full)
  );

  fpdc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .gains        (gains),
    .q_valid      (q_valid),
    .q_item       (q_rd_item),
    .q_pop        (q_pop),
    .back_busy    (back_busy),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .move_x       (move_x),
    .move_y       (move_y),
    .move_z       (move_z),
    .turn_x       (turn_x),
    .turn_y       (turn_y),
    .turn_z       (turn_z)
  );

`ifndef SYNTHESIS
  // Front backpressure only when the queue actually holds items
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !sample_ready |-> q_valid)
    else $error("sample_ready low with empty queue");

  // Datapath never pops an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // A popped item always puts the datapath to work
  a_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> back_busy)
    else $error("datapath idle after pop");
`endif

endmodule

// File: sim/six_axis_force_pd_compensator_test.sv
// Testbench for six_axis_force_pd_compensator: drives sample beats, predicts each
// result from its own model of the deadband/PD/scale/clamp path and checks every field.
// Depends on fpdc_pkg (axis codes, widths, register map) and the RTL of the block.
module six_axis_force_pd_compensator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fpdc_pkg::*;

  // Gain groups shared by the axes
  localparam int GRP_XY  = 0;
  localparam int GRP_Z   = 1;
  localparam int GRP_TRQ = 2;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;

  typedef logic [AXES-1:0][IN_W-1:0] sample_t;

  typedef struct packed {
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic signed [16:0] move_z;
    logic signed [17:0] turn_x;
    logic signed [17:0] turn_y;
    logic signed [17:0] turn_z;
  } motion_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               sample_valid;
  logic               sample_ready;
  logic signed [21:0] force_x, force_y, force_z, torque_x, torque_y, torque_z;
  logic               result_valid;
  logic               result_ready;
  logic signed [15:0] move_x, move_y;
  logic signed [16:0] move_z;
  logic signed [17:0] turn_x, turn_y, turn_z;

  // Model state: gains and the last shrunk error per axis
  longint gain_kp [3];
  longint gain_kd [3];
  longint stored_err [AXES];

  motion_t pending_motion [$];
  motion_t want;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  bit      tx_idle_on, rx_idle_on;
  int      hold_request = 0;
  int      hold_left = 0;
  int      stall_left = 0;

  six_axis_force_pd_compensator u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .force_x      (force_x),
    .force_y      (force_y),
    .force_z      (force_z),
    .torque_x     (torque_x),
    .torque_y     (torque_y),
    .torque_z     (torque_z),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .move_x       (move_x),
    .move_y       (move_y),
    .move_z       (move_z),
    .turn_x       (turn_x),
    .turn_y       (turn_y),
    .turn_z       (turn_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic longint dead_zone(input int axis);
    if (axis <= AX_FY) return 1536;
    if (axis == AX_FZ) return 3072;
    return 154;
  endfunction

  function automatic longint clamp_of(input int axis);
    if (axis <= AX_FY) return 31457;
    if (axis == AX_FZ) return 36700;
    return 91436;
  endfunction

  // Round to nearest, ties away from zero
  function automatic longint div_round(input longint n, input longint d);
    longint mag;
    mag = (n < 0) ? -n : n;
    mag = (mag + d / 2) / d;
    return (n < 0) ? -mag : mag;
  endfunction

  function automatic motion_t predict_motion(input sample_t s);
    motion_t m;
    longint  x, zone, e, acc, r;
    longint  res [AXES];
    int      grp;
    for (int i = 0; i < AXES; i++) begin
      x = longint'($signed(s[i]));
      zone = dead_zone(i);
      res[i] = 0;
      // on or inside the deadband: zero out, error memory untouched
      if (x > zone || x < -zone) begin
        e = (x < 0) ? x + zone : x - zone;
        grp = (i <= AX_FY) ? GRP_XY : (i == AX_FZ) ? GRP_Z : GRP_TRQ;
        acc = gain_kp[grp] * e + gain_kd[grp] * (e - stored_err[i]);
        stored_err[i] = e;
        // 2^-18 sum units -> 2^-20 m (/1000) or 2^-20 rad (*3.14/180)
        r = (i < AX_TX) ? div_round(acc, 250) : div_round(acc * 157, 2250);
        if (r > clamp_of(i)) r = clamp_of(i);
        if (r < -clamp_of(i)) r = -clamp_of(i);
        res[i] = r;
      end
    end
    m.move_x = 16'(res[AX_FX]);
    m.move_y = 16'(res[AX_FY]);
    m.move_z = 17'(res[AX_FZ]);
    m.turn_x = 18'(res[AX_TX]);
    m.turn_y = 18'(res[AX_TY]);
    m.turn_z = 18'(res[AX_TZ]);
    return m;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [21:0] random_reading(input int axis);
    longint mag;
    case ($urandom_range(0, 9))
      0, 1: return 22'($urandom);
      2: mag = $urandom_range(0, 32'(dead_zone(axis)));
      3: mag = dead_zone(axis) + $urandom_range(0, 2);
      default: mag = dead_zone(axis) + $urandom_range(1, (axis < AX_TX) ? 20000 : 4000);
    endcase
    return $urandom_range(0, 1) ? 22'(-mag) : 22'(mag);
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    for (int i = 0; i < AXES; i++) s[i] = random_reading(i);
    return s;
  endfunction

  // Every axis at its own deadband plus offset, optionally negated
  function automatic sample_t edge_sample(input longint offset, input bit negate);
    sample_t s;
    longint  v;
    for (int i = 0; i < AXES; i++) begin
      v = dead_zone(i) + offset;
      s[i] = negate ? 22'(-v) : 22'(v);
    end
    return s;
  endfunction

  // One sample beat; valid is left high so back-to-back beats need no toggle
  task automatic send_sample(input sample_t s);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    force_x  <= $signed(s[AX_FX]);
    force_y  <= $signed(s[AX_FY]);
    force_z  <= $signed(s[AX_FZ]);
    torque_x <= $signed(s[AX_TX]);
    torque_y <= $signed(s[AX_TY]);
    torque_z <= $signed(s[AX_TZ]);
    do @(posedge clk); while (!sample_ready);
    pending_motion.push_back(predict_motion(s));
  endtask

  task automatic release_sample();
    sample_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_motion.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_KP_FORCE_XY: gain_kp[GRP_XY]  = data;
      REG_KD_FORCE_XY: gain_kd[GRP_XY]  = $signed(data);
      REG_KP_FORCE_Z:  gain_kp[GRP_Z]   = data;
      REG_KD_FORCE_Z:  gain_kd[GRP_Z]   = $signed(data);
      REG_KP_TORQUE:   gain_kp[GRP_TRQ] = data;
      REG_KD_TORQUE:   gain_kd[GRP_TRQ] = $signed(data);
      default: ;  // unmapped index, block drops it
    endcase
    @(posedge clk);
  endtask

  // Only called with the block idle; an unmapped write goes first each time
  task automatic set_gains(input logic [15:0] kp_xy, kd_xy, kp_z, kd_z, kp_t, kd_t);
    write_reg(3'(REG_KD_TORQUE) + 3'($urandom_range(1, 2)), 16'($urandom));
    write_reg(REG_KP_FORCE_XY, kp_xy);
    write_reg(REG_KD_FORCE_XY, kd_xy);
    write_reg(REG_KP_FORCE_Z, kp_z);
    write_reg(REG_KD_FORCE_Z, kd_z);
    write_reg(REG_KP_TORQUE, kp_t);
    write_reg(REG_KD_TORQUE, kd_t);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_sample(random_sample());
    release_sample();
    wait_drained();
  endtask

  // ---------------------------------------------------------------- tests

  // Reset gains: deadband edges, sign changes, field extremes, mixed axes
  task automatic test_reset_gains();
    sample_t mixed;
    for (int i = 0; i < AXES; i++)
      mixed[i] = (i % 2 == 0) ? 22'(dead_zone(i)) : 22'(-(dead_zone(i) + 500));
    send_sample('0);
    send_sample(edge_sample(0, 1'b0));
    send_sample(edge_sample(0, 1'b1));
    send_sample(edge_sample(1, 1'b0));
    send_sample(edge_sample(1, 1'b1));
    send_sample({AXES{22'h1FFFFF}});
    send_sample({AXES{22'h200000}});
    send_sample(edge_sample(1000, 1'b0));
    send_sample(mixed);
    release_sample();
    wait_drained();
  endtask

  // Gain registers at their extremes
  task automatic test_gain_extremes();
    set_gains(16'hFFFF, 16'h8000, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h8000);
    send_sample({AXES{22'h1FFFFF}});
    send_sample({AXES{22'h200000}});
    send_sample(edge_sample(1, 1'b0));
    send_sample(edge_sample(1, 1'b1));
    send_sample('0);
    send_sample(edge_sample(3, 1'b0));
    release_sample();
    wait_drained();
    set_gains(16'h0000, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000, 16'h7FFF);
    send_sample(edge_sample(1, 1'b0));
    send_sample({AXES{22'h200000}});
    send_sample({AXES{22'h1FFFFF}});
    send_sample(edge_sample(1, 1'b1));
    send_sample(edge_sample(2, 1'b0));
    release_sample();
    wait_drained();
  endtask

  // Result side held off long enough that the block backs up its input
  task automatic test_output_hold_off();
    set_gains(16'd563, 16'(-102), 16'd384, 16'(-77), 16'd640, 16'(-128));
    tx_idle_on = 1'b0;
    hold_request = HOLD_CYCLES;
    run_random(24);
    tx_idle_on = 1'b1;
  endtask

  // Sender stops until every result is back, then resumes
  task automatic test_drain_pause();
    run_random(10);
    run_random(10);
  endtask

  task automatic test_random_settings();
    set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
    run_random(105);
    // typical gains, outputs mostly below the clamp
    set_gains(16'($urandom_range(128, 1024)), 16'(int'($urandom_range(0, 512)) - 256),
              16'($urandom_range(128, 1024)), 16'(int'($urandom_range(0, 512)) - 256),
              16'($urandom_range(128, 1024)), 16'(int'($urandom_range(0, 512)) - 256));
    run_random(105);
    set_gains(16'h0000, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h0001, 16'h8000);
    run_random(105);
    set_gains(16'($urandom_range(0, 2048)), 16'($urandom), 16'($urandom_range(0, 2048)),
              16'($urandom), 16'($urandom_range(0, 2048)), 16'($urandom));
    run_random(105);
  endtask

  // Tail of the run: back to reset gains, full rate, no idling
  task automatic test_steady_stream();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_gains(16'd563, 16'(-102), 16'd384, 16'(-77), 16'd640, 16'(-128));
    run_random(100);
  endtask

  // ---------------------------------------------------------------- result side

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic signed [17:0] exp_v, got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_motion.size() == 0) begin
        $display("%0t: result beat with no prediction pending", $time);
        mismatches++;
      end else begin
        want = pending_motion.pop_front();
        check_field("move_x", want.move_x, move_x);
        check_field("move_y", want.move_y, move_y);
        check_field("move_z", want.move_z, move_z);
        check_field("turn_x", want.turn_x, turn_x);
        check_field("turn_y", want.turn_y, turn_y);
        check_field("turn_z", want.turn_z, turn_z);
      end
    end
  end

  // Watchdog on cycles with no beat or write
  always @(posedge clk) begin
    if ((sample_valid && sample_ready) || (result_valid && result_ready) || cfg_we || rst)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = REG_KP_FORCE_XY;
    cfg_data     = '0;
    sample_valid = 1'b0;
    force_x      = '0;
    force_y      = '0;
    force_z      = '0;
    torque_x     = '0;
    torque_y     = '0;
    torque_z     = '0;
    result_ready = 1'b0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    gain_kp[GRP_XY]  = 563;
    gain_kd[GRP_XY]  = -102;
    gain_kp[GRP_Z]   = 384;
    gain_kd[GRP_Z]   = -77;
    gain_kp[GRP_TRQ] = 640;
    gain_kd[GRP_TRQ] = -128;
    for (int i = 0; i < AXES; i++) stored_err[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_gains();
    test_gain_extremes();
    test_output_hold_off();
    test_drain_pause();
    test_random_settings();
    test_steady_stream();

    // allow for any stray late beat
    repeat (30) @(posedge clk);
    if (pending_motion.size() != 0) begin
      $display("%0t: %0d predictions never matched", $time, pending_motion.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
